// ===== design/weighted_budget_meter_top_defines.svh =====
// ----------------------------------------------------------------------------
// Weighted budget meter assertion macros
// Shared property wrappers for the meter's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_BUDGET_METER_TOP_DEFINES_SVH
`define WEIGHTED_BUDGET_METER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define WBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/wbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Weighted budget meter package
// Item types, function and register codes, and shared helpers.
// ----------------------------------------------------------------------------
package wbm_pkg;

  // Weight table geometry.
  localparam int KINDS    = 512;
  localparam int KIDX_W   = $clog2(KINDS);
  localparam int KIND_W   = 9;
  localparam int CFG_IDX_W = 8;

  // Item functions.
  typedef enum logic [2:0] {
    FN_SPEND_KIND = 3'd0,
    FN_SPEND_RAW  = 3'd1,
    FN_BEGIN_CALL = 3'd2,
    FN_END_CALL   = 3'd3,
    FN_TICK       = 3'd4,
    FN_SET_WEIGHT = 3'd5
  } func_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUM_LIMIT   = 8'd0,
    REG_CALL_LIMIT  = 8'd1,
    REG_MS_LIMIT    = 8'd2,
    REG_METER_EN    = 8'd3
  } cfg_reg_e;

  // Input item.
  typedef struct packed {
    logic [2:0]        func;
    logic [KIND_W-1:0] kind;
    logic [31:0]       amount;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic        notify;
    logic        out_of_resources;
    logic        out_of_time;
    logic [63:0] total_used;
    logic [63:0] call_used;
    logic [63:0] remaining_units;
    logic [63:0] total_time_ms;
    logic [31:0] remaining_ms;
  } out_item_t;

  // Saturating 64-bit add.
  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

// ===== design/weighted_budget_meter_top.sv =====
// ----------------------------------------------------------------------------
// Weighted budget meter
// Charges step weights or raw amounts against per-call and cumulative
// budgets, tracks call time and reports budget exhaustion per item.
// ----------------------------------------------------------------------------
// The meter takes one item per clock cycle while in_stall is low and returns
// one result item for every input item, in order; each item passes through
// stage one, stage two and the output register. The rate is set by
// the single weight memory, which is read once at acceptance and written at
// acceptance by set-weight items, so no forwarding is needed. After reset the
// weight memory is filled with ones over all KINDS entries (512 by default),
// during which in_stall stays high; configuration writes are taken at any time.
// Three items can be held in flight while the output is stalled.
module weighted_budget_meter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  wbm_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output wbm_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_wdata
);

  // Configuration registers.
  logic [63:0] cum_limit_r;
  logic [63:0] call_limit_r;
  logic [31:0] ms_limit_r;
  logic        meter_en_r;

  // Weight memory and its fill sweep.
  logic [31:0]                weight_ram [wbm_pkg::KINDS];
  logic [31:0]                rd_weight_r;
  logic                       clearing_r;
  logic [wbm_pkg::KIDX_W-1:0] clr_idx_r;

  // Stage one: item accepted, weight read.
  logic        s1_valid_r;
  logic [2:0]  s1_func_r;
  logic [31:0] s1_amount_r;
  logic        s1_kind_ok_r;

  // Stage two: state updated.
  logic s2_valid_r;
  logic s2_spend_r;

  // Meter state.
  logic [63:0] total_units_r, total_units_nxt;
  logic [63:0] call_units_r,  call_units_nxt;
  logic        timer_run_r,   timer_run_nxt;
  logic [31:0] elapsed_ms_r,  elapsed_ms_nxt;
  logic [63:0] total_ms_r,    total_ms_nxt;

  // Output register.
  logic                out_valid_r;
  wbm_pkg::out_item_t  out_data_r;

  logic                       accept;
  logic                       out_free;
  logic                       s2_adv;
  logic                       s1_adv;
  logic                       kind_ok;
  logic [wbm_pkg::KIDX_W-1:0] kind_idx;
  logic [63:0]                charge;
  logic                       res_out;
  logic                       time_out;

  // Handshake and pipeline advance.
  assign out_free  = !out_valid_r || !out_stall;
  assign s2_adv    = s2_valid_r && out_free;
  assign s1_adv    = s1_valid_r && (!s2_valid_r || s2_adv);
  assign in_stall  = clearing_r || (s1_valid_r && !s1_adv);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Kind range check and table address.
  assign kind_ok  = {23'd0, in_data.kind} < 32'(wbm_pkg::KINDS);
  assign kind_idx = wbm_pkg::KIDX_W'(in_data.kind);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cum_limit_r  <= '0;
      call_limit_r <= '0;
      ms_limit_r   <= '0;
      meter_en_r   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wbm_pkg::REG_CUM_LIMIT:  cum_limit_r  <= cfg_wdata;
        wbm_pkg::REG_CALL_LIMIT: call_limit_r <= cfg_wdata;
        wbm_pkg::REG_MS_LIMIT:   ms_limit_r   <= cfg_wdata[31:0];
        wbm_pkg::REG_METER_EN:   meter_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Fill sweep after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      clr_idx_r <= clr_idx_r + wbm_pkg::KIDX_W'(1);
      if (clr_idx_r == wbm_pkg::KIDX_W'(wbm_pkg::KINDS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Weight memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      weight_ram[clr_idx_r] <= 32'd1;
    end else if (accept && in_data.func == wbm_pkg::FN_SET_WEIGHT && kind_ok) begin
      weight_ram[kind_idx] <= in_data.amount;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_weight_r <= weight_ram[kind_idx];
    end
  end

  // Stage one registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func_r    <= in_data.func;
      s1_amount_r  <= in_data.amount;
      s1_kind_ok_r <= kind_ok;
    end
  end

  // Charge of a spend item.
  always_comb begin
    if (s1_func_r == wbm_pkg::FN_SPEND_RAW) begin
      charge = {32'd0, s1_amount_r};
    end else if (s1_kind_ok_r) begin
      charge = {32'd0, rd_weight_r};
    end else begin
      charge = '0;
    end
  end

  // State update for the item leaving stage one.
  always_comb begin
    total_units_nxt = total_units_r;
    call_units_nxt  = call_units_r;
    timer_run_nxt   = timer_run_r;
    elapsed_ms_nxt  = elapsed_ms_r;
    total_ms_nxt    = total_ms_r;
    unique case (s1_func_r)
      wbm_pkg::FN_SPEND_KIND, wbm_pkg::FN_SPEND_RAW: begin
        total_units_nxt = wbm_pkg::sat_add64(total_units_r, charge);
        call_units_nxt  = wbm_pkg::sat_add64(call_units_r, charge);
      end
      wbm_pkg::FN_BEGIN_CALL, wbm_pkg::FN_END_CALL: begin
        total_ms_nxt   = wbm_pkg::sat_add64(total_ms_r, {32'd0, elapsed_ms_r});
        elapsed_ms_nxt = '0;
        call_units_nxt = '0;
        timer_run_nxt  = (s1_func_r == wbm_pkg::FN_BEGIN_CALL) && (ms_limit_r != '0);
      end
      wbm_pkg::FN_TICK: begin
        if (timer_run_r && elapsed_ms_r != {32{1'b1}}) begin
          elapsed_ms_nxt = elapsed_ms_r + 32'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_units_r <= '0;
      call_units_r  <= '0;
      timer_run_r   <= 1'b0;
      elapsed_ms_r  <= '0;
      total_ms_r    <= '0;
    end else if (s1_adv) begin
      total_units_r <= total_units_nxt;
      call_units_r  <= call_units_nxt;
      timer_run_r   <= timer_run_nxt;
      elapsed_ms_r  <= elapsed_ms_nxt;
      total_ms_r    <= total_ms_nxt;
    end
  end

  // Stage two registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_r <= 1'b1;
    end else if (s2_adv) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_spend_r <= (s1_func_r == wbm_pkg::FN_SPEND_KIND) ||
                    (s1_func_r == wbm_pkg::FN_SPEND_RAW);
    end
  end

  // Exhaustion flags from the state after the stage-two item.
  assign res_out  = meter_en_r &&
                    (((call_limit_r != '0) && (call_units_r >= call_limit_r)) ||
                     ((cum_limit_r != '0) && (total_units_r >= cum_limit_r)));
  assign time_out = meter_en_r && (ms_limit_r != '0) && timer_run_r &&
                    (elapsed_ms_r >= ms_limit_r);

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_data_r.notify           <= s2_spend_r && (res_out || time_out);
      out_data_r.out_of_resources <= res_out;
      out_data_r.out_of_time      <= time_out;
      out_data_r.total_used       <= total_units_r;
      out_data_r.call_used        <= call_units_r;
      out_data_r.remaining_units  <= (cum_limit_r > total_units_r) ?
                                     (cum_limit_r - total_units_r) : '0;
      out_data_r.total_time_ms    <= total_ms_r;
      out_data_r.remaining_ms     <= (ms_limit_r > elapsed_ms_r) ?
                                     (ms_limit_r - elapsed_ms_r) : '0;
    end
  end

  // Checks.
`include "weighted_budget_meter_top_defines.svh"

  `WBM_ASSERT_NOW(a_no_accept_in_fill, clearing_r, in_stall, "item accepted during fill")
  `WBM_ASSERT_NEXT(a_s1_holds, s1_valid_r && s2_valid_r && !s2_adv, s1_valid_r && s2_valid_r, "stage lost while blocked")
  `WBM_ASSERT_NOW(a_timer_idle_zero, !timer_run_r, elapsed_ms_r == '0, "elapsed time while timer stopped")
  `WBM_ASSERT_NOW(a_call_le_total, 1'b1, call_units_r <= total_units_r, "call units exceed total")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted budget meter testbench
// Drives spend, call, tick and weight items into the meter, predicts every
// result item from a behavioral copy of the meter state, and compares each
// result field by field. A directed part covers the limits and special
// cases. Random phases under several register settings follow, and a final
// phase holds off the output long enough to fill the meter.
// ----------------------------------------------------------------------------
module testbench;

  // Function codes that the meter does not define, and unused register slots.
  localparam logic [2:0] FN_UNUSED_LO = 3'd6;
  localparam logic [2:0] FN_UNUSED_HI = 3'd7;
  localparam logic [wbm_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO  = 8'd4;
  localparam logic [wbm_pkg::CFG_IDX_W-1:0] REG_UNUSED_TOP = 8'd255;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 250;
  localparam int RANDOM_PHASES  = 7;
  localparam int MAX_REPORTS    = 40;
  localparam logic [63:0] ALL_ONES64 = {64{1'b1}};

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  wbm_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  wbm_pkg::out_item_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [wbm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [63:0]                   cfg_wdata;

  weighted_budget_meter_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted meter state and register copies.
  logic [31:0] weight_mem [wbm_pkg::KINDS];
  logic [63:0] units_total;
  logic [63:0] units_call;
  logic        timer_on;
  logic [31:0] ms_elapsed;
  logic [63:0] ms_total;
  logic [63:0] lim_cum;
  logic [63:0] lim_call;
  logic [31:0] lim_ms;
  logic        meter_on;

  wbm_pkg::out_item_t expected_readings[$];

  // Run bookkeeping.
  int  error_count;
  int  items_sent;
  int  readings_checked;
  int  notify_seen;
  int  timeout_seen;
  int  long_holds;
  int  quiet_cycles;
  bit  send_gaps;
  bit  recv_gaps;
  bit  hold_req;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturating add of two 64-bit unsigned values.
  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s < a) ? ALL_ONES64 : s;
  endfunction

  function automatic logic units_exhausted();
    return meter_on && ((lim_call != 0 && units_call >= lim_call) ||
                        (lim_cum != 0 && units_total >= lim_cum));
  endfunction

  function automatic logic time_exhausted();
    return meter_on && lim_ms != 0 && timer_on && ms_elapsed >= lim_ms;
  endfunction

  // Folds the running call into the totals; begin call restarts the timer if a time limit is set.
  function automatic void close_call(input logic restart);
    ms_total   = add_sat(ms_total, {32'd0, ms_elapsed});
    ms_elapsed = '0;
    units_call = '0;
    timer_on   = restart && (lim_ms != 0);
  endfunction

  // Applies one item to the predicted state and returns the expected reading.
  function automatic wbm_pkg::out_item_t meter_step(input wbm_pkg::in_item_t item);
    wbm_pkg::out_item_t r;
    logic [63:0]        charge;
    r = '0;
    case (item.func)
      wbm_pkg::FN_SPEND_KIND, wbm_pkg::FN_SPEND_RAW: begin
        if (item.func == wbm_pkg::FN_SPEND_RAW) charge = {32'd0, item.amount};
        else if (item.kind < wbm_pkg::KINDS) charge = {32'd0, weight_mem[item.kind]};
        else charge = '0;
        units_total = add_sat(units_total, charge);
        units_call  = add_sat(units_call, charge);
        r.notify    = units_exhausted() || time_exhausted();
      end
      wbm_pkg::FN_BEGIN_CALL: close_call(1'b1);
      wbm_pkg::FN_END_CALL:   close_call(1'b0);
      wbm_pkg::FN_TICK: begin
        if (timer_on && ms_elapsed != 32'hFFFF_FFFF) ms_elapsed = ms_elapsed + 32'd1;
      end
      wbm_pkg::FN_SET_WEIGHT: begin
        if (item.kind < wbm_pkg::KINDS) weight_mem[item.kind] = item.amount;
      end
      default: ;
    endcase
    r.out_of_resources = units_exhausted();
    r.out_of_time      = time_exhausted();
    r.total_used       = units_total;
    r.call_used        = units_call;
    r.remaining_units  = (lim_cum > units_total) ? lim_cum - units_total : '0;
    r.total_time_ms    = ms_total;
    r.remaining_ms     = (lim_ms > ms_elapsed) ? lim_ms - ms_elapsed : '0;
    return r;
  endfunction

  // Prints one mismatch line, up to a cap, and counts it.
  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // Compares one accepted result with the oldest expected reading.
  task automatic check_reading(input wbm_pkg::out_item_t got);
    wbm_pkg::out_item_t want;
    string              tag;
    if (expected_readings.size() == 0) begin
      report_error("result item arrived with nothing expected");
      return;
    end
    want = expected_readings.pop_front();
    tag  = $sformatf("result %0d", readings_checked);
    readings_checked++;
    if (got.notify) notify_seen++;
    if (got.out_of_time) timeout_seen++;
    if (got.notify !== want.notify)
      report_error($sformatf("%s notify got %0b want %0b", tag, got.notify, want.notify));
    if (got.out_of_resources !== want.out_of_resources)
      report_error($sformatf("%s out_of_resources got %0b want %0b", tag,
                             got.out_of_resources, want.out_of_resources));
    if (got.out_of_time !== want.out_of_time)
      report_error($sformatf("%s out_of_time got %0b want %0b", tag,
                             got.out_of_time, want.out_of_time));
    if (got.total_used !== want.total_used)
      report_error($sformatf("%s total_used got %h want %h", tag,
                             got.total_used, want.total_used));
    if (got.call_used !== want.call_used)
      report_error($sformatf("%s call_used got %h want %h", tag,
                             got.call_used, want.call_used));
    if (got.remaining_units !== want.remaining_units)
      report_error($sformatf("%s remaining_units got %h want %h", tag,
                             got.remaining_units, want.remaining_units));
    if (got.total_time_ms !== want.total_time_ms)
      report_error($sformatf("%s total_time_ms got %h want %h", tag,
                             got.total_time_ms, want.total_time_ms));
    if (got.remaining_ms !== want.remaining_ms)
      report_error($sformatf("%s remaining_ms got %h want %h", tag,
                             got.remaining_ms, want.remaining_ms));
  endtask

  // Result checker: every accepted result item is compared.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_reading(out_data);
  end

  // Receiver: random stall before each result, plus one long hold on request.
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        long_holds++;
      end
      n = recv_gaps ? $urandom_range(0, 9) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: ends the run when no handshake of any kind completes for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("weighted_budget_meter_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic wbm_pkg::in_item_t make_item(input logic [2:0] func,
                                                  input logic [wbm_pkg::KIND_W-1:0] kind,
                                                  input logic [31:0] amount);
    wbm_pkg::in_item_t item;
    item.func   = func;
    item.kind   = kind;
    item.amount = amount;
    return item;
  endfunction

  // Random kind index within the table.
  function automatic logic [wbm_pkg::KIND_W-1:0] random_kind();
    return wbm_pkg::KIND_W'($urandom_range(0, wbm_pkg::KINDS - 1));
  endfunction

  // Sends one item; valid stays high afterwards until the next item or idle.
  task automatic send_item(input wbm_pkg::in_item_t item);
    int                 gap;
    wbm_pkg::out_item_t predicted;
    gap = send_gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    predicted = meter_step(item);
    expected_readings = {expected_readings, predicted};
    items_sent++;
  endtask

  // Drops valid and waits until every expected result has been checked.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes one register and updates the predicted copy.
  task automatic write_reg(input logic [wbm_pkg::CFG_IDX_W-1:0] index,
                           input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      wbm_pkg::REG_CUM_LIMIT:  lim_cum  = value;
      wbm_pkg::REG_CALL_LIMIT: lim_call = value;
      wbm_pkg::REG_MS_LIMIT:   lim_ms   = value[31:0];
      wbm_pkg::REG_METER_EN:   meter_on = value[0];
      default: ;
    endcase
  endtask

  // Random item inside a call; raw amounts are mostly small so limits get hit.
  function automatic wbm_pkg::in_item_t random_body_item();
    int          pick;
    logic [31:0] amount;
    logic [2:0]  func;
    pick   = $urandom_range(0, 99);
    amount = $urandom();
    if (pick < 35) func = wbm_pkg::FN_SPEND_KIND;
    else if (pick < 55) begin
      func = wbm_pkg::FN_SPEND_RAW;
      if ($urandom_range(0, 15) != 0) amount = $urandom_range(0, 300);
    end else if (pick < 80) func = wbm_pkg::FN_TICK;
    else if (pick < 92) begin
      func = wbm_pkg::FN_SET_WEIGHT;
      if ($urandom_range(0, 7) != 0) amount = $urandom_range(0, 200);
    end else if (pick < 96) func = wbm_pkg::FN_BEGIN_CALL;
    else func = $urandom_range(0, 1) ? FN_UNUSED_LO : FN_UNUSED_HI;
    return make_item(func, random_kind(), amount);
  endfunction

  // One call: begin, a few items, end; now and then begin or end is dropped.
  task automatic run_random_call();
    int n;
    n = $urandom_range(1, 12);
    if ($urandom_range(0, 9) != 0)
      send_item(make_item(wbm_pkg::FN_BEGIN_CALL, random_kind(), $urandom()));
    repeat (n) send_item(random_body_item());
    if ($urandom_range(0, 7) != 0)
      send_item(make_item(wbm_pkg::FN_END_CALL, random_kind(), $urandom()));
  endtask

  // Default registers: limits off, meter on, timer never starts.
  task automatic test_reset_defaults();
    send_item(make_item(wbm_pkg::FN_SPEND_KIND, '0, '0));
    send_item(make_item(wbm_pkg::FN_SPEND_RAW, '1, '0));
    send_item(make_item(wbm_pkg::FN_TICK, '0, '1));
    send_item(make_item(wbm_pkg::FN_BEGIN_CALL, '0, '0));
    send_item(make_item(wbm_pkg::FN_TICK, '1, '0));
    send_item(make_item(wbm_pkg::FN_END_CALL, '1, '1));
    send_item(make_item(FN_UNUSED_LO, '1, '1));
    send_item(make_item(FN_UNUSED_HI, '0, '0));
    wait_idle();
  endtask

  // Small limits, weight extremes, timeout, mid-call limit change, meter off.
  task automatic test_directed_limits();
    write_reg(wbm_pkg::REG_CUM_LIMIT, 64'd10);
    write_reg(wbm_pkg::REG_CALL_LIMIT, 64'd3);
    write_reg(wbm_pkg::REG_MS_LIMIT, 64'd2);
    write_reg(wbm_pkg::REG_METER_EN, 64'd1);
    send_item(make_item(wbm_pkg::FN_SET_WEIGHT, '0, '0));
    send_item(make_item(wbm_pkg::FN_SET_WEIGHT, '1, 32'hFFFF_FFFF));
    send_item(make_item(wbm_pkg::FN_BEGIN_CALL, '0, '0));
    send_item(make_item(wbm_pkg::FN_SPEND_KIND, '0, '0));
    send_item(make_item(wbm_pkg::FN_SPEND_KIND, 9'd1, '0));
    send_item(make_item(wbm_pkg::FN_SPEND_RAW, '0, 32'd2));
    send_item(make_item(wbm_pkg::FN_TICK, '0, '0));
    send_item(make_item(wbm_pkg::FN_TICK, '0, '0));
    send_item(make_item(wbm_pkg::FN_SPEND_KIND, 9'd5, '0));
    wait_idle();
    // Raising the timer limit in the middle of a call clears the timeout.
    write_reg(wbm_pkg::REG_MS_LIMIT, 64'd100);
    send_item(make_item(wbm_pkg::FN_TICK, '0, '0));
    send_item(make_item(wbm_pkg::FN_SPEND_RAW, '0, 32'hFFFF_FFFF));
    send_item(make_item(wbm_pkg::FN_END_CALL, '0, '0));
    send_item(make_item(wbm_pkg::FN_SPEND_KIND, '1, '0));
    wait_idle();
    // With the meter off every flag reads zero.
    write_reg(wbm_pkg::REG_METER_EN, 64'd0);
    write_reg(REG_UNUSED_LO, ALL_ONES64);
    write_reg(REG_UNUSED_TOP, ALL_ONES64);
    send_item(make_item(wbm_pkg::FN_SPEND_RAW, '0, 32'd1));
    send_item(make_item(wbm_pkg::FN_BEGIN_CALL, '0, '0));
    send_item(make_item(wbm_pkg::FN_TICK, '0, '0));
    send_item(make_item(wbm_pkg::FN_END_CALL, '0, '0));
    wait_idle();
  endtask

  // Random phases, each under its own register setting and idling pattern.
  task automatic test_random_traffic();
    int target;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      send_gaps = (phase != 2 && phase != 5);
      recv_gaps = (phase != 2 && phase != 6);
      case (phase)
        1: begin
          write_reg(wbm_pkg::REG_CUM_LIMIT, '0);
          write_reg(wbm_pkg::REG_CALL_LIMIT, '0);
          write_reg(wbm_pkg::REG_MS_LIMIT, '0);
          write_reg(wbm_pkg::REG_METER_EN, 64'd1);
        end
        2: begin
          write_reg(wbm_pkg::REG_CUM_LIMIT, ALL_ONES64);
          write_reg(wbm_pkg::REG_CALL_LIMIT, ALL_ONES64);
          write_reg(wbm_pkg::REG_MS_LIMIT, {32'd0, 32'hFFFF_FFFF});
          write_reg(wbm_pkg::REG_METER_EN, 64'd1);
        end
        default: begin
          write_reg(wbm_pkg::REG_CUM_LIMIT, units_total + 64'($urandom_range(1, 20000)));
          write_reg(wbm_pkg::REG_CALL_LIMIT, 64'($urandom_range(1, 3000)));
          write_reg(wbm_pkg::REG_MS_LIMIT, 64'($urandom_range(1, 15)));
          write_reg(wbm_pkg::REG_METER_EN, (phase == 3) ? 64'd0 : 64'd1);
        end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) run_random_call();
      wait_idle();
    end
  endtask

  // The receiver holds off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    send_gaps = 1'b0;
    recv_gaps = 1'b1;
    write_reg(wbm_pkg::REG_CUM_LIMIT, units_total + 64'd5000);
    write_reg(wbm_pkg::REG_MS_LIMIT, 64'd4);
    write_reg(wbm_pkg::REG_METER_EN, 64'd1);
    hold_req = 1'b1;
    repeat (4) run_random_call();
    wait_idle();
  endtask

  // Stimulus sequence.
  initial begin
    error_count = 0;
    items_sent = 0;
    readings_checked = 0;
    notify_seen = 0;
    timeout_seen = 0;
    long_holds = 0;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    hold_req = 1'b0;
    for (int k = 0; k < wbm_pkg::KINDS; k++) weight_mem[wbm_pkg::KIDX_W'(k)] = 32'd1;
    units_total = '0;
    units_call  = '0;
    timer_on    = 1'b0;
    ms_elapsed  = '0;
    ms_total    = '0;
    lim_cum     = '0;
    lim_call    = '0;
    lim_ms      = '0;
    meter_on    = 1'b1;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_directed_limits();
    test_random_traffic();
    test_backpressure();

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Checked %0d result items for %0d input items over %0d random phases.",
             readings_checked, items_sent, RANDOM_PHASES);
    $display("Saw %0d notify and %0d timeout results; %0d long output hold(s).",
             notify_seen, timeout_seen, long_holds);
    if (error_count == 0) begin
      $display("weighted_budget_meter_top test passed");
    end else begin
      $display("weighted_budget_meter_top test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/wbm_pkg.sv
design/weighted_budget_meter_top.sv
tb/testbench.sv
